### src/hav_pkg.sv
// ----------------------------------------------------------------------------
// hav_pkg: shared types, constants and table functions for haversine_distance
// Fixed-point formats, CORDIC arctangent table and gain constant, unit
// conversion constants.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int FRAC_BITS = 30;
  localparam int ANG_W = FRAC_BITS + 3;
  localparam int CORDIC_ITERS_DEF = 24;
  localparam int ATAN_N = 32;
  localparam int NLANE = 4;

  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int DIST_W = 25;
  localparam int CFG_W = 29;
  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 32;

  // lane roles in the rotation bank
  localparam int LN_DLAT = 0;
  localparam int LN_DLON = 1;
  localparam int LN_CLAT = 2;
  localparam int LN_RLAT = 3;

  // register indexes
  localparam logic REG_REF_LAT = 1'b0;
  localparam logic REG_REF_LON = 1'b1;

  localparam logic [29:0] UDEG_FULL = 30'd360000000;
  localparam logic [29:0] UDEG_HALF = 30'd180000000;
  localparam logic [27:0] UDEG_QUART = 28'd90000000;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] UDEG_RAD_Q60 = (PI_Q60 + 64'd90000000) / 64'd180000000;
  localparam int K_W = 35;
  localparam int KL_W = 18;
  localparam int SH_COS = 60 - FRAC_BITS;
  localparam int SH_HALF = 61 - FRAC_BITS;

  localparam int R_W = 23;
  localparam logic [R_W-1:0] EARTH_R_M = 23'd6371000;
  localparam logic [DIST_W-1:0] HALF_CIRC_M = 25'd20015087;

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [ANG_W-2:0] mag_t;
  typedef logic [FRAC_BITS:0] unit_t;
  typedef logic [FRAC_BITS+1:0] root_t;

  function automatic logic [127:0] udiv128(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q;
    logic [127:0] r;
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[126:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [127:0] isqrt128(input logic [127:0] v);
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] t;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[125:0], v[2*j +: 2]};
      t = {q[125:0], 2'b01};
      if (r >= t) begin
        r = r - t;
        q = {q[126:0], 1'b1};
      end else begin
        q = {q[126:0], 1'b0};
      end
    end
    return q;
  endfunction

  // atan(2^-i) by its power series in Q62, rounded to FRAC_BITS
  function automatic logic [63:0] atan_q(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] res;
    int e;
    sum = '0;
    if (i == 0) begin
      res = (PI_Q60 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = 64'(udiv128(128'd1 << (62 - e), 128'(2 * k + 1)));
          if ((k & 1) != 0) sum = sum - term;
          else sum = sum + term;
        end
      end
      res = (sum + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    end
    return res;
  endfunction

  // floor(1 / gain) in Q format for the given iteration count
  function automatic logic [63:0] gain_inv_q(input int iters);
    logic [127:0] p;
    logic [127:0] g;
    logic [127:0] gi;
    p = 128'd1 << 60;
    for (int i = 0; i < ATAN_N; i++) begin
      if (i < iters) p = p + (p >> (2 * i));
    end
    p = (p + (128'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    g = isqrt128(p << FRAC_BITS);
    gi = udiv128(128'd1 << (2 * FRAC_BITS), g);
    return gi[63:0];
  endfunction

endpackage

### src/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance to a configured reference point
// Streams coordinate pairs in, streams distances in meters out.
//
//   channel   dir   handshake               payload
//   in_       in    in_tvalid/in_tready     cur_lat, cur_lon
//   out_      out   out_tvalid/out_tready   dist_m
//   cfg_      in    cfg_wr_en               ref_lat (0), ref_lon (1)
//
// One transfer per cycle sustained unless the output stalls; the pipeline depth
// is set by the two unrolled CORDICs and the one-bit-per-stage square root.
// Reset (rst_n low, synchronous) clears all valid bits and both reference
// registers. When out_tready is low with a result held, the whole pipeline
// holds and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module haversine_distance #(
  parameter int CORDIC_ITERS = hav_pkg::CORDIC_ITERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [27:0] cur_lat, [56:28] cur_lon
  input  logic [hav_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [24:0] dist_m
  output logic [hav_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [hav_pkg::CFG_W-1:0]         cfg_wdata
);
  import hav_pkg::*;

  logic signed [LAT_W-1:0] ref_lat_r;
  logic signed [LON_W-1:0] ref_lon_r;
  logic en;

  logic  fr_valid, rot_valid, mix_valid, sq_valid;
  ang_t  theta [NLANE];
  logic  fr_neg [NLANE];
  ang_t  cos_v [NLANE];
  ang_t  sin_v [NLANE];
  logic  rot_neg [NLANE];
  unit_t a_v, b_v;
  unit_t sq_in [2];
  root_t sq_q [2];
  logic [DIST_W-1:0] dist_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r <= '0;
      ref_lon_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_REF_LAT: ref_lat_r <= cfg_wdata[LAT_W-1:0];
        REG_REF_LON: ref_lon_r <= cfg_wdata[LON_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  hav_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .cur_lat  (in_tdata[LAT_W-1:0]),
    .cur_lon  (in_tdata[LAT_W+LON_W-1:LAT_W]),
    .ref_lat  (ref_lat_r),
    .ref_lon  (ref_lon_r),
    .out_valid(fr_valid),
    .theta    (theta),
    .neg      (fr_neg)
  );

  hav_rot_bank #(.CORDIC_ITERS(CORDIC_ITERS)) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fr_valid),
    .theta    (theta),
    .neg_in   (fr_neg),
    .out_valid(rot_valid),
    .cos_out  (cos_v),
    .sin_out  (sin_v),
    .neg_out  (rot_neg)
  );

  hav_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rot_valid),
    .cos_in   (cos_v),
    .sin_in   (sin_v),
    .neg_in   (rot_neg),
    .out_valid(mix_valid),
    .a_out    (a_v),
    .b_out    (b_v)
  );

  // lane 0: sqrt(1 - a), lane 1: sqrt(a)
  assign sq_in[0] = b_v;
  assign sq_in[1] = a_v;

  hav_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (mix_valid),
    .v_in     (sq_in),
    .out_valid(sq_valid),
    .q_out    (sq_q)
  );

  hav_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_valid),
    .x_in     (sq_q[0]),
    .y_in     (sq_q[1]),
    .out_valid(out_tvalid),
    .dist_m   (dist_m)
  );

  assign out_tdata = OUT_TDATA_W'(dist_m);

endmodule

### src/hav_front.sv
// ----------------------------------------------------------------------------
// hav_front: coordinate differences to CORDIC angles
// Wraps the microdegree differences and latitudes, folds latitudes into the
// first quadrant and converts to radians, halving the difference angles, in four lanes over four stages.
// ----------------------------------------------------------------------------
module hav_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [hav_pkg::LAT_W-1:0] cur_lat,
  input  logic signed [hav_pkg::LON_W-1:0] cur_lon,
  input  logic signed [hav_pkg::LAT_W-1:0] ref_lat,
  input  logic signed [hav_pkg::LON_W-1:0] ref_lon,
  output logic                          out_valid,
  output hav_pkg::ang_t                 theta [hav_pkg::NLANE],
  output logic                          neg   [hav_pkg::NLANE]
);
  import hav_pkg::*;

  localparam logic [K_W-1:0] K = K_W'(UDEG_RAD_Q60);
  localparam logic [KL_W-1:0] KL = K[KL_W-1:0];
  localparam logic [K_W-KL_W-1:0] KH = K[K_W-1:KL_W];
  localparam int PL_W = 28 + KL_W;
  localparam int PH_W = 28 + K_W - KL_W;

  function automatic logic [29:0] abs30(input logic signed [29:0] v);
    return v[29] ? 30'(-v) : 30'(v);
  endfunction

  function automatic logic [27:0] wrap_mag(input logic [29:0] mag);
    logic [29:0] x;
    x = mag;
    if (x >= UDEG_FULL) x = x - UDEG_FULL;
    if (x > UDEG_HALF) x = UDEG_FULL - x;
    return x[27:0];
  endfunction

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [29:0] mag_r [NLANE];
  logic [27:0] m_r   [NLANE];
  logic        n2_r  [NLANE];
  logic        n3_r  [NLANE];
  logic [PL_W-1:0] pl_r [NLANE];
  logic [PH_W-1:0] ph_r [NLANE];
  ang_t        th_r  [NLANE];
  logic        n4_r  [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[LN_DLAT] <= abs30(30'(ref_lat) - 30'(cur_lat));
      mag_r[LN_DLON] <= abs30(30'(ref_lon) - 30'(cur_lon));
      mag_r[LN_CLAT] <= abs30(30'(cur_lat));
      mag_r[LN_RLAT] <= abs30(30'(ref_lat));
    end
  end

  // latitudes past a quarter turn use cos(x) = -cos(180 - x)
  always_ff @(posedge clk) begin
    logic [27:0] w;
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        w = wrap_mag(mag_r[l]);
        if ((l == LN_CLAT || l == LN_RLAT) && w > UDEG_QUART) begin
          m_r[l]  <= 28'(UDEG_HALF) - w;
          n2_r[l] <= 1'b1;
        end else begin
          m_r[l]  <= w;
          n2_r[l] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        pl_r[l] <= PL_W'(m_r[l]) * PL_W'(KL);
        ph_r[l] <= PH_W'(m_r[l]) * PH_W'(KH);
        n3_r[l] <= n2_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] p;
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        p = 64'(pl_r[l]) + (64'(ph_r[l]) << KL_W);
        if (l == LN_CLAT || l == LN_RLAT)
          th_r[l] <= ang_t'((p + (64'd1 << (SH_COS - 1))) >> SH_COS);
        else
          th_r[l] <= ang_t'((p + (64'd1 << (SH_HALF - 1))) >> SH_HALF);
        n4_r[l] <= n3_r[l];
      end
    end
  end

  assign out_valid = v4_r;
  assign theta = th_r;
  assign neg = n4_r;

endmodule

### src/hav_rot_bank.sv
// ----------------------------------------------------------------------------
// hav_rot_bank: four-lane rotation CORDIC
// One iteration per stage; gives cosine and sine of each lane angle.
// ----------------------------------------------------------------------------
module hav_rot_bank #(
  parameter int CORDIC_ITERS = hav_pkg::CORDIC_ITERS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  hav_pkg::ang_t theta   [hav_pkg::NLANE],
  input  logic          neg_in  [hav_pkg::NLANE],
  output logic          out_valid,
  output hav_pkg::ang_t cos_out [hav_pkg::NLANE],
  output hav_pkg::ang_t sin_out [hav_pkg::NLANE],
  output logic          neg_out [hav_pkg::NLANE]
);
  import hav_pkg::*;

  localparam ang_t GAIN_INV = ang_t'(gain_inv_q(CORDIC_ITERS));

  logic v_r [CORDIC_ITERS+1];
  ang_t x_r [CORDIC_ITERS+1][NLANE];
  ang_t y_r [CORDIC_ITERS+1][NLANE];
  ang_t z_r [CORDIC_ITERS+1][NLANE];
  logic n_r [CORDIC_ITERS+1][NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        x_r[0][l] <= GAIN_INV;
        y_r[0][l] <= '0;
        z_r[0][l] <= theta[l];
        n_r[0][l] <= neg_in[l];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_it
    localparam ang_t ATAN = ang_t'(atan_q(i));

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= v_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NLANE; l++) begin
          if (!z_r[i][l][ANG_W-1]) begin
            x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] - ATAN;
          end else begin
            x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] + ATAN;
          end
          n_r[i+1][l] <= n_r[i][l];
        end
      end
    end
  end

  assign out_valid = v_r[CORDIC_ITERS];
  assign cos_out = x_r[CORDIC_ITERS];
  assign sin_out = y_r[CORDIC_ITERS];
  assign neg_out = n_r[CORDIC_ITERS];

endmodule

### src/hav_mix.sv
// ----------------------------------------------------------------------------
// hav_mix: haversine term a
// a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), clamped to [0, 1],
// together with 1 - a. Products are rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module hav_mix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hav_pkg::ang_t  cos_in [hav_pkg::NLANE],
  input  hav_pkg::ang_t  sin_in [hav_pkg::NLANE],
  input  logic           neg_in [hav_pkg::NLANE],
  output logic           out_valid,
  output hav_pkg::unit_t a_out,
  output hav_pkg::unit_t b_out
);
  import hav_pkg::*;

  localparam int P_W = 2 * (ANG_W - 1);
  localparam logic signed [ANG_W:0] ONE_S = $signed((ANG_W+1)'(ONE_Q));

  typedef logic [P_W-1:0] prod_t;

  function automatic mag_t mag(input ang_t v);
    return v[ANG_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  function automatic mag_t rnd(input prod_t p);
    logic [P_W:0] s;
    s = (P_W+1)'(p) + ((P_W+1)'(1) << (FRAC_BITS - 1));
    return mag_t'(s >> FRAC_BITS);
  endfunction

  logic  v1_r, v2_r, v3_r, v4_r, v5_r;
  prod_t p_lat_r, p_lon_r, p_cc_r, p2_r;
  logic  sg1_r, sg2_r, sg3_r;
  mag_t  ss_lat_r, ss_lon_r, cc_r, ss_lat3_r;
  logic signed [ANG_W:0] a_r;
  unit_t a_out_r, b_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ANG_W:0] t_s;
    if (en) begin
      p_lat_r <= P_W'(mag(sin_in[LN_DLAT])) * P_W'(mag(sin_in[LN_DLAT]));
      p_lon_r <= P_W'(mag(sin_in[LN_DLON])) * P_W'(mag(sin_in[LN_DLON]));
      p_cc_r  <= P_W'(mag(cos_in[LN_CLAT])) * P_W'(mag(cos_in[LN_RLAT]));
      sg1_r   <= cos_in[LN_CLAT][ANG_W-1] ^ neg_in[LN_CLAT]
               ^ cos_in[LN_RLAT][ANG_W-1] ^ neg_in[LN_RLAT];

      ss_lat_r <= rnd(p_lat_r);
      ss_lon_r <= rnd(p_lon_r);
      cc_r     <= rnd(p_cc_r);
      sg2_r    <= sg1_r;

      p2_r      <= P_W'(cc_r) * P_W'(ss_lon_r);
      ss_lat3_r <= ss_lat_r;
      sg3_r     <= sg2_r;

      t_s = $signed({2'b00, rnd(p2_r)});
      if (sg3_r) t_s = -t_s;
      a_r <= $signed({2'b00, ss_lat3_r}) + t_s;

      if (a_r[ANG_W]) begin
        a_out_r <= '0;
        b_out_r <= ONE_Q;
      end else if (a_r > ONE_S) begin
        a_out_r <= ONE_Q;
        b_out_r <= '0;
      end else begin
        a_out_r <= a_r[FRAC_BITS:0];
        b_out_r <= ONE_Q - a_r[FRAC_BITS:0];
      end
    end
  end

  assign out_valid = v5_r;
  assign a_out = a_out_r;
  assign b_out = b_out_r;

endmodule

### src/hav_sqrt.sv
// ----------------------------------------------------------------------------
// hav_sqrt: two-lane pipelined square root
// Digit-by-digit recurrence, one result bit per stage, truncated result in
// the same fixed-point format as the operand.
// ----------------------------------------------------------------------------
module hav_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  hav_pkg::unit_t v_in  [2],
  output logic           out_valid,
  output hav_pkg::root_t q_out [2]
);
  import hav_pkg::*;

  localparam int SQ_N = FRAC_BITS + 2;
  localparam int RAD_W = 2 * SQ_N;
  localparam int RW = FRAC_BITS + 4;

  logic               v_r   [SQ_N+1];
  logic [RAD_W-1:0]   rad_r [SQ_N+1][2];
  root_t              q_r   [SQ_N+1][2];
  logic [RW-1:0]      r_r   [SQ_N+1][2];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  // operand scaled by 2^FRAC_BITS so the root keeps the same format
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rad_r[0][l] <= RAD_W'({v_in[l], {FRAC_BITS{1'b0}}});
        q_r[0][l]   <= '0;
        r_r[0][l]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_dig
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (en) v_r[k+1] <= v_r[k];
    end

    always_ff @(posedge clk) begin
      logic [RW+1:0] rr;
      logic [RW+1:0] t;
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rr = {r_r[k][l], rad_r[k][l][RAD_W-1 -: 2]};
          t  = (RW+2)'({q_r[k][l], 2'b01});
          if (rr >= t) begin
            r_r[k+1][l] <= RW'(rr - t);
            q_r[k+1][l] <= {q_r[k][l][FRAC_BITS:0], 1'b1};
          end else begin
            r_r[k+1][l] <= RW'(rr);
            q_r[k+1][l] <= {q_r[k][l][FRAC_BITS:0], 1'b0};
          end
          rad_r[k+1][l] <= rad_r[k][l] << 2;
        end
      end
    end
  end

  assign out_valid = v_r[SQ_N];
  assign q_out = q_r[SQ_N];

endmodule

### src/hav_back.sv
// ----------------------------------------------------------------------------
// hav_back: central angle and meters
// Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)), doubled, scaled by the
// earth radius, rounded and saturated at half the circumference.
// ----------------------------------------------------------------------------
module hav_back #(
  parameter int CORDIC_ITERS = hav_pkg::CORDIC_ITERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  hav_pkg::root_t              x_in,
  input  hav_pkg::root_t              y_in,
  output logic                        out_valid,
  output logic [hav_pkg::DIST_W-1:0]  dist_m
);
  import hav_pkg::*;

  localparam int IP_W = ANG_W - FRAC_BITS;
  localparam int FP_W = FRAC_BITS + R_W;
  localparam int M_W = IP_W + R_W + 1;

  logic v_r [CORDIC_ITERS+1];
  ang_t x_r [CORDIC_ITERS+1];
  ang_t y_r [CORDIC_ITERS+1];
  ang_t z_r [CORDIC_ITERS+1];

  logic              o1_v_r, o2_v_r;
  logic [IP_W-1:0]   ip_r;
  logic [FP_W-1:0]   fp_r;
  logic [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= ang_t'({1'b0, x_in});
      y_r[0] <= ang_t'({1'b0, y_in});
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_it
    localparam ang_t ATAN = ang_t'(atan_q(i));

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else if (en) v_r[i+1] <= v_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][ANG_W-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_v_r <= 1'b0;
      o2_v_r <= 1'b0;
    end else if (en) begin
      o1_v_r <= v_r[CORDIC_ITERS];
      o2_v_r <= o1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ANG_W:0] c2;
    logic [M_W-1:0]        m;
    if (en) begin
      // small negative residue of the angle counts as zero
      c2 = {z_r[CORDIC_ITERS], 1'b0};
      if (c2[ANG_W]) c2 = '0;
      ip_r <= c2[ANG_W-1:FRAC_BITS];
      fp_r <= FP_W'(c2[FRAC_BITS-1:0]) * FP_W'(EARTH_R_M);

      m = M_W'(ip_r) * M_W'(EARTH_R_M)
        + M_W'((fp_r + (FP_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      if (m > M_W'(HALF_CIRC_M)) dist_r <= HALF_CIRC_M;
      else dist_r <= m[DIST_W-1:0];
    end
  end

  assign out_valid = o2_v_r;
  assign dist_m = dist_r;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for haversine_distance
// Streams coordinate pairs under random source gaps and sink stalls and
// predicts every distance with a bit-exact fixed-point CORDIC model. Each
// received distance is checked in order against the expected one. The
// reference point is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
module testbench;
  import hav_pkg::*;

  localparam int ITERS = 24;
  localparam int FB = 30;
  localparam logic [63:0] PI_FIX60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_TO_RAD60 = (PI_FIX60 + 64'd90000000) / 64'd180000000;
  localparam longint FULL_TURN = 360000000;
  localparam longint HALF_TURN = 180000000;
  localparam longint QUART_TURN = 90000000;
  localparam longint UNIT = longint'(1) << FB;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] lat;
  } coord_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  haversine_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  coord_t coord_queue[$];
  logic [DIST_W-1:0] dist_expected[$];
  longint atan_lut[ITERS];
  longint cordic_start;
  longint home_lat;
  longint home_lon;
  bit no_gaps;
  bit run_done;
  int mismatches;
  int n_sent;
  int n_recv;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- math
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic longint root_fix(input longint v);
    if (v <= 0) return 0;
    return longint'(isqrt64(64'(v) << FB));
  endfunction

  function automatic longint mul_fix(input longint a, input longint b);
    logic [127:0] p;
    longint r;
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b) + (128'd1 << (FB - 1));
    r = longint'(p[FB +: 64]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  task automatic build_tables();
    logic [63:0] p;
    longint acc;
    longint g;
    atan_lut[0] = longint'((PI_FIX60 + (64'd1 << (61 - FB))) >> (62 - FB));
    for (int i = 1; i < ITERS; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) <= 62) begin
          if (k & 1) acc -= longint'((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
          else acc += longint'((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
        end
      end
      atan_lut[i] = longint'((64'(acc) + (64'd1 << (61 - FB))) >> (62 - FB));
    end
    p = 64'd1 << 60;
    for (int i = 0; i < ITERS; i++) p = p + (p >> (2 * i));
    p = (p + (64'd1 << (59 - FB))) >> (60 - FB);
    g = root_fix(longint'(p));
    cordic_start = longint'((64'd1 << (2 * FB)) / 64'(g));
  endtask

  function automatic longint sine_of(input longint theta, input bit want_cos);
    longint x, y, z, dx, dy;
    x = cordic_start;
    y = 0;
    z = theta;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    return want_cos ? x : y;
  endfunction

  function automatic longint angle_of(input longint xi, input longint yi);
    longint x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic longint fold_udeg(input longint d);
    longint m;
    m = (d < 0 ? -d : d) % FULL_TURN;
    return (m > HALF_TURN) ? FULL_TURN - m : m;
  endfunction

  function automatic longint udeg_rad(input longint m, input int sh);
    logic [63:0] p;
    p = 64'(m) * DEG_TO_RAD60;
    return longint'((p + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint cos_latitude(input longint lat);
    longint m;
    bit flip;
    m = fold_udeg(lat);
    flip = m > QUART_TURN;
    if (flip) m = HALF_TURN - m;
    m = sine_of(udeg_rad(m, 60 - FB), 1'b1);
    return flip ? -m : m;
  endfunction

  function automatic longint half_sine_sq(input longint d);
    longint s;
    s = sine_of(udeg_rad(fold_udeg(d), 61 - FB), 1'b0);
    return mul_fix(s, s);
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_m(input coord_t c);
    longint lat, lon, a, ang;
    logic [63:0] uc, m;
    lat = longint'(c.lat);
    lon = longint'(c.lon);
    a = half_sine_sq(home_lat - lat) + mul_fix(mul_fix(cos_latitude(lat),
        cos_latitude(home_lat)), half_sine_sq(home_lon - lon));
    if (a < 0) a = 0;
    if (a > UNIT) a = UNIT;
    ang = 2 * angle_of(root_fix(UNIT - a), root_fix(a));
    if (ang < 0) ang = 0;
    uc = 64'(ang);
    m = (uc >> FB) * 64'd6371000
        + (((uc & ((64'd1 << FB) - 1)) * 64'd6371000 + (64'd1 << (FB - 1))) >> FB);
    if (m > 64'(HALF_CIRC_M)) m = 64'(HALF_CIRC_M);
    return m[DIST_W-1:0];
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(99) >= 17);
      if (!in_tvalid || in_tready) begin
        if (coord_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 17)) begin
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'(coord_queue.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int idle_cycles;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        dist_expected.push_back(great_circle_m(coord_t'(in_tdata[LAT_W+LON_W-1:0])));
        n_sent++;
      end
      if (out_tvalid && out_tready) begin
        n_recv++;
        if (dist_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected distance %0d", out_tdata[DIST_W-1:0]);
        end else if (out_tdata[DIST_W-1:0] !== dist_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch #%0d: expected %0d, got %0d", n_recv,
                     dist_expected[0], out_tdata[DIST_W-1:0]);
          void'(dist_expected.pop_front());
        end else begin
          void'(dist_expected.pop_front());
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || run_done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic set_home(input longint lat, input longint lon);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_REF_LAT;
    cfg_wdata <= CFG_W'(lat);
    @(posedge clk);
    cfg_index <= REG_REF_LON;
    cfg_wdata <= CFG_W'(lon);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    home_lat = longint'(signed'(LAT_W'(lat)));
    home_lon = longint'(signed'(LON_W'(lon)));
  endtask

  task automatic add_coord(input longint lat, input longint lon);
    coord_t c;
    c.lat = LAT_W'(lat);
    c.lon = LON_W'(lon);
    coord_queue.push_back(c);
  endtask

  task automatic drain();
    while (coord_queue.size() > 0 || in_tvalid || dist_expected.size() > 0) @(posedge clk);
  endtask

  task automatic random_coords(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 65)
        add_coord($urandom_range(180000000) - QUART_TURN, $urandom_range(360000000) - HALF_TURN);
      else if (pick < 85)
        // close to the reference point: short distances
        add_coord(home_lat + $urandom_range(20000) - 10000,
                  home_lon + $urandom_range(20000) - 10000);
      else
        add_coord(longint'(signed'(LAT_W'($urandom))), longint'(signed'(LON_W'($urandom))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_REF_LAT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    no_gaps = 1'b0;
    run_done = 1'b0;
    mismatches = 0;
    n_sent = 0;
    n_recv = 0;
    home_lat = 0;
    home_lon = 0;
    build_tables();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: registers still at reset value
    add_coord(0, 0);
    add_coord(0, HALF_TURN);
    add_coord(0, -HALF_TURN);
    add_coord(QUART_TURN, 0);
    add_coord(-QUART_TURN, 12345678);
    add_coord(1, 1);
    add_coord(-1, -1);
    add_coord((1 << 27) - 1, (1 << 28) - 1);
    add_coord(-(1 << 27), -(1 << 28));
    add_coord(100000000, 0);
    add_coord(-130000000, 170000000);
    add_coord(0, 179999999);
    drain();

    set_home(QUART_TURN, HALF_TURN);
    add_coord(-QUART_TURN, 0);
    add_coord(QUART_TURN, -HALF_TURN);
    add_coord(89999999, HALF_TURN);
    add_coord(0, 0);
    add_coord(-(1 << 27), (1 << 28) - 1);
    random_coords(150);
    drain();

    set_home(-QUART_TURN, -HALF_TURN);
    add_coord(QUART_TURN, HALF_TURN);
    add_coord(-QUART_TURN, -HALF_TURN);
    no_gaps = 1'b1;
    random_coords(160);
    drain();
    no_gaps = 1'b0;

    set_home((1 << 27) - 1, -(1 << 28));
    add_coord(-(1 << 27), (1 << 28) - 1);
    random_coords(150);
    drain();

    set_home(-(1 << 27), (1 << 28) - 1);
    random_coords(150);
    drain();

    set_home(48856600, 2352200);
    add_coord(-48856600, -177647800);
    add_coord(48856601, 2352200);
    random_coords(170);
    drain();

    repeat (120) @(posedge clk);
    run_done = 1'b1;
    $display("sent %0d coordinate pairs over 6 reference points, received %0d distances",
             n_sent, n_recv);
    $display("%0d distance mismatches", mismatches);
    if (mismatches == 0 && dist_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
